[rtl/ttbts_pkg.sv]
// shared types and codes for the two-tier bound table store
package ttbts_pkg;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int AGE_W   = 16;
  localparam int SCORE_W = 16;
  localparam int LIMIT_W = 15;
  localparam int MOVE_W  = 8;
  localparam int SET_W   = 16;
  localparam int KEY_SET_LSB = 32;

  typedef enum logic [2:0] {
    ACT_REF_DEEP  = 3'd0,
    ACT_REF_NEW   = 3'd1,
    ACT_DEMOTE    = 3'd2,
    ACT_REPL_DEEP = 3'd3,
    ACT_REPL_NEW  = 3'd4,
    ACT_CLEARED   = 3'd5
  } action_t;

  typedef enum logic [0:0] {
    REG_SEARCH_AGE  = 1'b0,
    REG_SCORE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        [MOVE_W-1:0]  move;
    logic signed [SCORE_W-1:0] upper;
    logic signed [SCORE_W-1:0] lower;
    logic        [AGE_W-1:0]   age;
    logic        [DEPTH_W-1:0] depth;
  } info_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    info_t            info;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/ttbts_ram.sv]
// generic single-port-write, registered-read synchronous ram
module ttbts_ram #(
  parameter int WIDTH     = 128,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/two_tier_bound_table_store.sv]
// top level: two-tier transposition table with read-modify-write over two set memories
// store: the transfer captures the request and reads its set; S_CALC writes the set back
//   and registers the result once the output is free; the next store waits for S_IDLE
// clear: sweeps one set per cycle over all 2^INDEX_BITS sets, then S_FIN registers the result
// reset: synchronous; sets search age to 0 and score limit to 64 and runs the same sweep
//   (over all 2^INDEX_BITS sets, in_ready low) before the first transfer is taken
module two_tier_bound_table_store #(
  parameter int INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [ttbts_pkg::KEY_W-1:0]       in_hash_key,
  input  logic [ttbts_pkg::DEPTH_W-1:0]     in_search_depth,
  input  logic signed [ttbts_pkg::SCORE_W-1:0] in_window_low,
  input  logic signed [ttbts_pkg::SCORE_W-1:0] in_window_high,
  input  logic signed [ttbts_pkg::SCORE_W-1:0] in_found_score,
  input  logic [ttbts_pkg::MOVE_W-1:0]      in_best_move,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_action,
  output logic [ttbts_pkg::SET_W-1:0]       out_set_index,
  output logic signed [ttbts_pkg::SCORE_W-1:0] out_new_lower,
  output logic signed [ttbts_pkg::SCORE_W-1:0] out_new_upper
);
  import ttbts_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CALC  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  function automatic info_t refine_f(info_t s, logic signed [SCORE_W-1:0] beta,
                                     logic signed [SCORE_W-1:0] score,
                                     logic [LIMIT_W-1:0] lim, logic [AGE_W-1:0] age,
                                     logic [MOVE_W-1:0] mv);
    info_t r;
    logic signed [SCORE_W-1:0] lo;
    logic signed [SCORE_W-1:0] up;
    r  = s;
    lo = s.lower;
    up = s.upper;
    if (score < beta && score < up) up = score;
    if (score > lo) lo = score;
    if (lo > up) begin
      up = (score < beta) ? score : signed'({1'b0, lim});
      lo = score;
    end
    r.lower = lo;
    r.upper = up;
    r.age   = age;
    r.move  = mv;
    return r;
  endfunction

  function automatic info_t fresh_f(logic [DEPTH_W-1:0] depth,
                                    logic signed [SCORE_W-1:0] alpha,
                                    logic signed [SCORE_W-1:0] beta,
                                    logic signed [SCORE_W-1:0] score,
                                    logic [LIMIT_W-1:0] lim, logic [AGE_W-1:0] age,
                                    logic [MOVE_W-1:0] mv);
    info_t r;
    logic signed [SCORE_W-1:0] lim_s;
    lim_s   = signed'({1'b0, lim});
    r.depth = depth;
    r.age   = age;
    r.upper = (score < beta) ? score : lim_s;
    r.lower = (score > alpha) ? score : -lim_s;
    r.move  = mv;
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic report_r, report_nxt;

  logic [AGE_W-1:0]   search_age_r;
  logic [LIMIT_W-1:0] score_limit_r;

  logic [KEY_W-1:0]          key_r;
  logic [INDEX_BITS-1:0]     set_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic signed [SCORE_W-1:0] alpha_r;
  logic signed [SCORE_W-1:0] beta_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [MOVE_W-1:0]         move_r;

  logic                      out_valid_r;
  action_t                   out_action_r;
  logic [SET_W-1:0]          out_set_r;
  logic signed [SCORE_W-1:0] out_lower_r;
  logic signed [SCORE_W-1:0] out_upper_r;

  logic [INDEX_BITS-1:0] raddr;
  logic [INDEX_BITS-1:0] waddr;
  entry_t rd_deep, rd_new;
  entry_t deep_wdata, new_wdata;
  logic deep_we, new_we;

  logic in_xfer, out_free, calc_go, fin_go;
  logic match_d, match_n, hit_d, hit_n, repl_d, demote;
  info_t ref_d, ref_n, fresh_i, result_i;
  action_t act;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign calc_go  = (state_r == S_CALC) && out_free;
  assign fin_go   = (state_r == S_FIN) && out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_age_r  <= '0;
      score_limit_r <= LIMIT_W'(64);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEARCH_AGE:  search_age_r  <= cfg_data[AGE_W-1:0];
        REG_SCORE_LIMIT: score_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r   <= in_hash_key;
      set_r   <= in_hash_key[KEY_SET_LSB +: INDEX_BITS];
      depth_r <= in_search_depth;
      alpha_r <= in_window_low;
      beta_r  <= in_window_high;
      score_r <= in_found_score;
      move_r  <= in_best_move;
    end
  end

  assign raddr = (state_r == S_IDLE) ? in_hash_key[KEY_SET_LSB +: INDEX_BITS] : set_r;

  ttbts_ram #(.WIDTH(ENTRY_W), .ADDR_BITS(INDEX_BITS)) u_deep_ram (
    .clk   (clk),
    .we    (deep_we),
    .waddr (waddr),
    .wdata (deep_wdata),
    .raddr (raddr),
    .rdata (rd_deep)
  );

  ttbts_ram #(.WIDTH(ENTRY_W), .ADDR_BITS(INDEX_BITS)) u_new_ram (
    .clk   (clk),
    .we    (new_we),
    .waddr (waddr),
    .wdata (new_wdata),
    .raddr (raddr),
    .rdata (rd_new)
  );

  // slot decision
  always_comb begin
    match_d = (key_r == rd_deep.key);
    match_n = (key_r == rd_new.key);
    hit_d   = match_d && (depth_r == rd_deep.info.depth) && (alpha_r < score_r);
    hit_n   = match_n && (depth_r == rd_new.info.depth) && (alpha_r < score_r);
    repl_d  = match_d || (rd_deep.info.age < search_age_r) || (rd_deep.info.depth < depth_r);
    demote  = !match_d && (match_n || (rd_new.info.age < rd_deep.info.age) ||
              ((rd_new.info.age == rd_deep.info.age) &&
               (rd_new.info.depth <= rd_deep.info.depth)));
    ref_d   = refine_f(rd_deep.info, beta_r, score_r, score_limit_r, search_age_r, move_r);
    ref_n   = refine_f(rd_new.info, beta_r, score_r, score_limit_r, search_age_r, move_r);
    fresh_i = fresh_f(depth_r, alpha_r, beta_r, score_r, score_limit_r, search_age_r,
                      move_r);
    if (hit_d) begin
      act      = ACT_REF_DEEP;
      result_i = ref_d;
    end else if (hit_n) begin
      act      = ACT_REF_NEW;
      result_i = ref_n;
    end else if (repl_d) begin
      act      = demote ? ACT_DEMOTE : ACT_REPL_DEEP;
      result_i = fresh_i;
    end else begin
      act      = ACT_REPL_NEW;
      result_i = fresh_i;
    end
  end

  // write-back
  always_comb begin
    waddr      = (state_r == S_SWEEP) ? cnt_r : set_r;
    deep_we    = 1'b0;
    new_we     = 1'b0;
    deep_wdata = '0;
    new_wdata  = '0;
    if (state_r == S_SWEEP) begin
      deep_we = 1'b1;
      new_we  = 1'b1;
    end else if (calc_go) begin
      case (act)
        ACT_REF_DEEP: begin
          deep_we    = 1'b1;
          deep_wdata = '{key: rd_deep.key, info: ref_d};
        end
        ACT_REF_NEW: begin
          new_we    = 1'b1;
          new_wdata = '{key: rd_new.key, info: ref_n};
        end
        ACT_DEMOTE: begin
          deep_we    = 1'b1;
          new_we     = 1'b1;
          deep_wdata = '{key: key_r, info: fresh_i};
          new_wdata  = rd_deep;
        end
        ACT_REPL_DEEP: begin
          deep_we    = 1'b1;
          deep_wdata = '{key: key_r, info: fresh_i};
        end
        ACT_REPL_NEW: begin
          new_we    = 1'b1;
          new_wdata = '{key: key_r, info: fresh_i};
        end
        default: ;
      endcase
    end
  end

  // control
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    report_nxt = report_r;
    case (state_r)
      S_SWEEP: begin
        cnt_nxt = cnt_r + INDEX_BITS'(1);
        if (&cnt_r) begin
          state_nxt = report_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_mode) begin
            state_nxt  = S_SWEEP;
            cnt_nxt    = '0;
            report_nxt = 1'b1;
          end else begin
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (calc_go) state_nxt = S_IDLE;
      end
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_SWEEP;
      cnt_r    <= '0;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      report_r <= report_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (calc_go || fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      out_action_r <= act;
      out_set_r    <= SET_W'(set_r);
      out_lower_r  <= result_i.lower;
      out_upper_r  <= result_i.upper;
    end else if (fin_go) begin
      out_action_r <= ACT_CLEARED;
      out_set_r    <= '0;
      out_lower_r  <= '0;
      out_upper_r  <= '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_action_r;
  assign out_set_index = out_set_r;
  assign out_new_lower = out_lower_r;
  assign out_new_upper = out_upper_r;

  a_store_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_mode) |=> (state_r == S_CALC))
    else $error("store transfer did not enter calc");

  a_calc_result: assert property (@(posedge clk) disable iff (!rst_n)
    calc_go |=> (out_valid_r && out_action_r != ACT_CLEARED))
    else $error("store did not produce a store result");

  a_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    (calc_go && deep_we && new_we) |-> (act == ACT_DEMOTE))
    else $error("both slots written outside demotion");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC || state_r == S_SWEEP || state_r == S_FIN) |-> !in_xfer)
    else $error("transfer accepted while busy");

endmodule

[tb/tb_top.sv]
// testbench for the two-tier bound table store: directed and random stores and clears
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttbts_pkg::*;

  localparam int INDEX_BITS = 16;
  localparam int SET_COUNT  = 1 << INDEX_BITS;
  localparam int POOL_SIZE  = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 4 * SET_COUNT + 10000;

  typedef struct {
    logic                      mode;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } store_req_t;

  typedef struct {
    action_t                   action;
    logic [SET_W-1:0]          set_index;
    logic signed [SCORE_W-1:0] lower;
    logic signed [SCORE_W-1:0] upper;
  } table_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_mode;
  logic [KEY_W-1:0] in_hash_key;
  logic [DEPTH_W-1:0] in_search_depth;
  logic signed [SCORE_W-1:0] in_window_low;
  logic signed [SCORE_W-1:0] in_window_high;
  logic signed [SCORE_W-1:0] in_found_score;
  logic [MOVE_W-1:0] in_best_move;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_action;
  logic [SET_W-1:0] out_set_index;
  logic signed [SCORE_W-1:0] out_new_lower;
  logic signed [SCORE_W-1:0] out_new_upper;

  // table shadow and register copies
  logic [KEY_W-1:0] deep_keys [SET_COUNT];
  info_t            deep_info [SET_COUNT];
  logic [KEY_W-1:0] new_keys  [SET_COUNT];
  info_t            new_info  [SET_COUNT];
  logic [AGE_W-1:0]   table_age   = '0;
  logic [LIMIT_W-1:0] table_limit = 15'd64;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  table_result_t expected_writes [$];

  int mismatches = 0;
  int items_sent = 0;
  int clears_sent = 0;
  int settings_used = 0;
  int action_seen [6];
  int idle_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;

  two_tier_bound_table_store #(
    .INDEX_BITS(INDEX_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_hash_key(in_hash_key),
    .in_search_depth(in_search_depth),
    .in_window_low(in_window_low),
    .in_window_high(in_window_high),
    .in_found_score(in_found_score),
    .in_best_move(in_best_move),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_action(out_action),
    .out_set_index(out_set_index),
    .out_new_lower(out_new_lower),
    .out_new_upper(out_new_upper)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_table_model();
    for (int i = 0; i < SET_COUNT; i++) begin
      deep_keys[i] = '0;
      deep_info[i] = '0;
      new_keys[i]  = '0;
      new_info[i]  = '0;
    end
  endfunction

  function automatic info_t refine_bounds(info_t s, store_req_t r);
    int lo, up, sc, be;
    lo = $signed(s.lower);
    up = $signed(s.upper);
    sc = r.score;
    be = r.beta;
    if (sc < be && sc < up) up = sc;
    if (sc > lo) lo = sc;
    // unstable bounds: restart around the new score
    if (lo > up) begin
      up = (sc < be) ? sc : int'(table_limit);
      lo = sc;
    end
    s.lower = 16'(lo);
    s.upper = 16'(up);
    s.age   = table_age;
    s.move  = r.move;
    return s;
  endfunction

  function automatic info_t fresh_bounds(store_req_t r);
    info_t s;
    int lo, up, sc;
    sc = r.score;
    lo = -int'(table_limit);
    up = int'(table_limit);
    if (sc < int'(r.beta)) up = sc;
    if (sc > int'(r.alpha)) lo = sc;
    s.depth = r.depth;
    s.age   = table_age;
    s.lower = 16'(lo);
    s.upper = 16'(up);
    s.move  = r.move;
    return s;
  endfunction

  function automatic table_result_t predict_table_write(store_req_t r);
    table_result_t res;
    int unsigned set_no;
    info_t d, n, w;
    res = '{ACT_CLEARED, '0, '0, '0};
    if (r.mode) begin
      clear_table_model();
      return res;
    end
    set_no = r.key[KEY_SET_LSB +: INDEX_BITS];
    d = deep_info[set_no];
    n = new_info[set_no];
    if (r.key == deep_keys[set_no] && r.depth == d.depth && r.alpha < r.score) begin
      w = refine_bounds(d, r);
      deep_info[set_no] = w;
      res.action = ACT_REF_DEEP;
    end else if (r.key == new_keys[set_no] && r.depth == n.depth && r.alpha < r.score) begin
      w = refine_bounds(n, r);
      new_info[set_no] = w;
      res.action = ACT_REF_NEW;
    end else if (r.key == deep_keys[set_no] || d.age < table_age || d.depth < r.depth) begin
      res.action = ACT_REPL_DEEP;
      if (r.key != deep_keys[set_no] && (r.key == new_keys[set_no] || n.age < d.age ||
          (n.age == d.age && n.depth <= d.depth))) begin
        new_keys[set_no] = deep_keys[set_no];
        new_info[set_no] = deep_info[set_no];
        res.action = ACT_DEMOTE;
      end
      w = fresh_bounds(r);
      deep_keys[set_no] = r.key;
      deep_info[set_no] = w;
    end else begin
      w = fresh_bounds(r);
      new_keys[set_no] = r.key;
      new_info[set_no] = w;
      res.action = ACT_REPL_NEW;
    end
    res.set_index = set_no[15:0];
    res.lower = w.lower;
    res.upper = w.upper;
    return res;
  endfunction

  function automatic store_req_t make_store(logic mode, logic [KEY_W-1:0] key, int depth,
                                            int alpha, int beta, int score, int move);
    store_req_t r;
    r.mode  = mode;
    r.key   = key;
    r.depth = 8'(depth);
    r.alpha = 16'(alpha);
    r.beta  = 16'(beta);
    r.score = 16'(score);
    r.move  = 8'(move);
    return r;
  endfunction

  function automatic store_req_t random_store();
    int a, b, s;
    logic [KEY_W-1:0] k;
    int dep;
    if ($urandom_range(0, 99) < 80) begin
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      dep = $urandom_range(0, 3);
    end else begin
      k = {$urandom, $urandom};
      dep = $urandom_range(0, 255);
    end
    if ($urandom_range(0, 9) == 0) begin
      a = int'($urandom_range(0, 65534)) - 32767;
      b = int'($urandom_range(0, 65534)) - 32767;
      s = int'($urandom_range(0, 65534)) - 32767;
    end else begin
      a = int'($urandom_range(0, 200)) - 100;
      b = a + int'($urandom_range(1, 60));
      s = a + int'($urandom_range(0, 100)) - 20;
    end
    return make_store(1'b0, k, dep, a, b, s, $urandom_range(0, 255));
  endfunction

  task automatic send_item(input store_req_t r);
    int gap;
    int pick;
    gap = 0;
    pick = $urandom_range(0, 99);
    if (tx_idle_on) begin
      if (pick >= 90) gap = $urandom_range(10, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode         <= r.mode;
    in_hash_key     <= r.key;
    in_search_depth <= r.depth;
    in_window_low   <= r.alpha;
    in_window_high  <= r.beta;
    in_found_score  <= r.score;
    in_best_move    <= r.move;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_writes.push_back(predict_table_write(r));
    items_sent++;
    if (r.mode) clears_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEARCH_AGE) table_age = data;
    else table_limit = data[LIMIT_W-1:0];
    settings_used++;
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    int stall;
    int pick;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!rx_idle_on) begin
        out_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          stall = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (pick < 23) begin
          stall = $urandom_range(15, 60);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    table_result_t want;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected result, actual action %0d set %0d", $time, out_action,
                 out_set_index);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        action_seen[want.action]++;
        if ($isunknown({out_action, out_set_index, out_new_lower, out_new_upper})) begin
          $display("%0t: unknown bits in result, expected action %0d, actual %b", $time,
                   want.action, out_action);
          mismatches++;
        end
        check_field("action", want.action, out_action);
        check_field("set_index", want.set_index, out_set_index);
        check_field("new_lower", want.lower, out_new_lower);
        check_field("new_upper", want.upper, out_new_upper);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no transfer in %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_reset_state();
    do @(posedge clk); while (in_ready !== 1'b1);
    // empty slot reads as key 0 depth 0
    send_item(make_store(1'b0, 64'h0, 0, -1, 1, 0, 0));
    send_item(make_store(1'b0, 64'h0, 0, 5, 9, 5, 1));
    send_item(make_store(1'b0, '1, 255, -32767, 32767, 32767, 255));
    send_item(make_store(1'b0, 64'h0000_0000_FFFF_FFFF, 0, 32767, -32767, -32767, 8'h80));
    send_item(make_store(1'b0, 64'h8000_0000_0000_0000, 128, 0, 0, 0, 8'h7F));
    wait_results_drained();
  endtask

  task automatic test_replacement_chain();
    logic [KEY_W-1:0] ka, kb, kc;
    ka = 64'hA5A5_0005_0000_0001;
    kb = 64'h5A5A_0005_0000_0002;
    kc = 64'h0F0F_0005_FFFF_0003;
    write_reg(REG_SEARCH_AGE, 16'd10);
    send_item(make_store(1'b0, ka, 5, -10, 10, 3, 11));
    send_item(make_store(1'b0, kb, 3, -10, 10, 3, 12));
    send_item(make_store(1'b0, kb, 3, 0, 50, 20, 13));
    // fail-high above the stored upper bound forces the instability repair
    send_item(make_store(1'b0, ka, 5, -5, 2, 8, 14));
    send_item(make_store(1'b0, ka, 7, -5, 2, 1, 15));
    wait_results_drained();
    write_reg(REG_SEARCH_AGE, 16'd11);
    send_item(make_store(1'b0, kc, 1, -20, 20, 0, 16));
    send_item(make_store(1'b0, kb, 3, 100, 120, 50, 17));
    send_item(make_store(1'b0, kc, 1, -20, 20, -30, 18));
    wait_results_drained();
  endtask

  task automatic test_clear();
    send_item(make_store(1'b1, {$urandom, $urandom}, 255, 32767, -32767, 1, 255));
    send_item(make_store(1'b0, 64'h0, 0, -3, 3, 2, 9));
    send_item(make_store(1'b0, '1, 255, -40, 40, 7, 10));
    wait_results_drained();
  endtask

  task automatic test_score_limits();
    write_reg(REG_SCORE_LIMIT, 16'd0);
    send_item(make_store(1'b0, 64'h0000_1234_0000_0042, 9, 5, 5, 5, 1));
    wait_results_drained();
    // bit 15 of the write data lies outside the register
    write_reg(REG_SCORE_LIMIT, 16'hFFFF);
    write_reg(REG_SEARCH_AGE, 16'hFFFF);
    send_item(make_store(1'b0, 64'h0000_1234_0000_0043, 9, 32767, -32767, 0, 2));
    send_item(make_store(1'b0, 64'h0000_1234_0000_0043, 9, -32767, 32767, 32767, 3));
    wait_results_drained();
    write_reg(REG_SCORE_LIMIT, 16'd1);
    send_item(make_store(1'b0, 64'h0000_4321_0000_0044, 2, 4, 6, 4, 4));
    wait_results_drained();
  endtask

  task automatic test_random_phases();
    int clears_left;
    logic [15:0] age_set;
    logic [15:0] limit_set;
    logic [INDEX_BITS-1:0] pool_set [3];
    clears_left = 3;
    pool_set[0] = '0;
    pool_set[1] = INDEX_BITS'(7);
    pool_set[2] = '1;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: age_set = 16'd0;
        4: age_set = table_age + 16'd1;
        5: age_set = 16'hFFFF;
        default: age_set = 16'($urandom);
      endcase
      if (p == 1) limit_set = 16'd1;
      else if (p == 3) limit_set = 16'h7FFF;
      else limit_set = 16'($urandom_range(1, 32767));
      write_reg(REG_SEARCH_AGE, age_set);
      write_reg(REG_SCORE_LIMIT, limit_set);
      for (int i = 0; i < POOL_SIZE; i++) begin
        key_pool[i] = {$urandom, $urandom};
        key_pool[i][KEY_SET_LSB +: INDEX_BITS] = pool_set[i % 3];
      end
      if (p == 0) key_pool[0] = '0;
      rx_idle_on = (p != 2);
      tx_idle_on = (p != 2);
      repeat (90) begin
        if (clears_left > 0 && $urandom_range(0, 149) == 0) begin
          clears_left--;
          send_item(make_store(1'b1, {$urandom, $urandom}, $urandom_range(0, 255),
                               0, 0, 0, $urandom_range(0, 255)));
        end else begin
          send_item(random_store());
        end
      end
      wait_results_drained();
    end
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (24) send_item(random_store());
    tx_idle_on = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    repeat (8) send_item(random_store());
    wait_results_drained();
    repeat (8) send_item(random_store());
    wait_results_drained();
  endtask

  initial begin : main
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SEARCH_AGE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_hash_key = '0;
    in_search_depth = '0;
    in_window_low = '0;
    in_window_high = '0;
    in_found_score = '0;
    in_best_move = '0;
    foreach (action_seen[i]) action_seen[i] = 0;
    clear_table_model();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_replacement_chain();
    test_clear();
    test_score_limits();
    test_random_phases();
    test_backpressure();
    test_sender_pause();

    wait_results_drained();
    repeat (10) @(posedge clk);
    $display("ran %0d items including %0d clears across %0d register writes", items_sent,
             clears_sent, settings_used);
    $display("actions: refine deep %0d, refine new %0d, demote %0d, replace deep %0d, %s %0d, %s %0d",
             action_seen[ACT_REF_DEEP], action_seen[ACT_REF_NEW], action_seen[ACT_DEMOTE],
             action_seen[ACT_REPL_DEEP], "replace new", action_seen[ACT_REPL_NEW],
             "cleared", action_seen[ACT_CLEARED]);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
